[design/ssci_pkg.sv]
`default_nettype none

package ssci_pkg;

  localparam int STEP_W = 21;
  localparam int CFG_W  = 11;

  typedef enum logic [1:0] {
    CFG_ROW_COUNT      = 2'd0,
    CFG_COL_COUNT      = 2'd1,
    CFG_SCAN_DIRECTION = 2'd2,
    CFG_START_CORNER   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    CORNER_TOP_LEFT     = 2'd0,
    CORNER_TOP_RIGHT    = 2'd1,
    CORNER_BOTTOM_RIGHT = 2'd2,
    CORNER_BOTTOM_LEFT  = 2'd3
  } corner_t;

  localparam logic SCAN_ALONG_ROWS = 1'b0;
  localparam logic SCAN_ALONG_COLS = 1'b1;

  typedef struct packed {
    logic valid;
    logic oor;
  } tag_t;

endpackage

`default_nettype wire

[design/ssci_div.sv]
`default_nettype none

module ssci_div #(
  parameter int DW = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic [ssci_pkg::STEP_W-1:0] dividend,
  input  wire logic [DW-1:0]               divisor,
  input  wire ssci_pkg::tag_t              tag_in,
  output      logic [ssci_pkg::STEP_W-1:0] quotient,
  output      logic [DW-1:0]               remainder,
  output      ssci_pkg::tag_t              tag_out
);

  localparam int NW = ssci_pkg::STEP_W;

  logic [NW-1:0]  num  [0:NW];
  logic [NW-1:0]  quot [0:NW];
  logic [DW-1:0]  rem  [0:NW];
  ssci_pkg::tag_t tag  [0:NW];

  assign num[0]  = dividend;
  assign quot[0] = '0;
  assign rem[0]  = '0;
  assign tag[0]  = tag_in;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    localparam int B = NW - 1 - i;
    logic [DW:0]   trial;
    logic          ge;
    logic [NW-1:0] quot_next;

    assign trial = {rem[i], num[i][B]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb begin
      quot_next    = quot[i];
      quot_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i+1] <= '0;
      end else if (en) begin
        tag[i+1] <= tag[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[i+1]  <= num[i];
        quot[i+1] <= quot_next;
        rem[i+1]  <= ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
      end
    end
  end

  assign quotient  = quot[NW];
  assign remainder = rem[NW];
  assign tag_out   = tag[NW];

endmodule

`default_nettype wire

[design/serpentine_scan_cell_index_unit.sv]
// An accepted step passes stages 1 and 2, the divider, stages 3 and 4 and the output register.
// Throughput: one step per cycle while step_stall is low; a 21-stage restoring divider,
// one quotient bit per stage, sets the depth of the pipeline.
// A stalled output is held in a skid register and the pipeline freezes only once that fills.
// Reset is synchronous and active high; it clears all valid bits and sets the grid to 1 x 1,
// row scan from the top-left corner.
`default_nettype none

module serpentine_scan_cell_index_unit #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [ssci_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        step_valid,
  output      logic                        step_stall,
  input  wire logic [ssci_pkg::STEP_W-1:0] step_number,
  output      logic                        cell_valid,
  input  wire logic                        cell_stall,
  output      logic [ssci_pkg::STEP_W-1:0] cell_number,
  output      logic                        out_of_range
);

  localparam int SW   = ssci_pkg::STEP_W;
  localparam int CFW  = ssci_pkg::CFG_W;
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int DW   = (RW > CW) ? RW : CW;
  localparam int RCW  = (RW > CFW) ? RW : CFW;
  localparam int CCW  = (CW > CFW) ? CW : CFW;
  localparam int PW   = RW + CW;
  localparam int CMPW = (PW > SW) ? PW : SW;

  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic          scan_direction;
  logic [1:0]    start_corner;

  logic [RCW-1:0] row_ext;
  logic [CCW-1:0] col_ext;
  logic [RW-1:0]  row_clamp;
  logic [CW-1:0]  col_clamp;

  assign cfg_ready = 1'b1;
  assign row_ext   = RCW'(cfg_data);
  assign col_ext   = CCW'(cfg_data);

  always_comb begin
    priority if (row_ext == '0) begin
      row_clamp = RW'(1);
    end else if (row_ext > RCW'(MAX_ROWS)) begin
      row_clamp = RW'(MAX_ROWS);
    end else begin
      row_clamp = RW'(row_ext);
    end
    priority if (col_ext == '0) begin
      col_clamp = CW'(1);
    end else if (col_ext > CCW'(MAX_COLS)) begin
      col_clamp = CW'(MAX_COLS);
    end else begin
      col_clamp = CW'(col_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows           <= RW'(1);
      cols           <= CW'(1);
      scan_direction <= ssci_pkg::SCAN_ALONG_ROWS;
      start_corner   <= ssci_pkg::CORNER_TOP_LEFT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ssci_pkg::cfg_index_t'(cfg_index))
        ssci_pkg::CFG_ROW_COUNT:      rows           <= row_clamp;
        ssci_pkg::CFG_COL_COUNT:      cols           <= col_clamp;
        ssci_pkg::CFG_SCAN_DIRECTION: scan_direction <= cfg_data[0];
        ssci_pkg::CFG_START_CORNER:   start_corner   <= cfg_data[1:0];
      endcase
    end
  end

  logic skid_valid;
  logic adv;

  assign adv        = !skid_valid;
  assign step_stall = skid_valid;

  // Stage 1: step minus one, zero check and grid area.
  logic          v_s1;
  logic          zero_s1;
  logic [SW-1:0] step_s1;
  logic [SW-1:0] dm1_s1;
  logic [PW-1:0] area_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1 <= 1'b0;
    end else if (adv) begin
      v_s1 <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_s1 <= step_number == '0;
      step_s1 <= step_number;
      dm1_s1  <= step_number - SW'(1);
      area_s1 <= PW'(rows) * PW'(cols);
    end
  end

  // Stage 2: range check.
  ssci_pkg::tag_t tag_s2;
  logic [SW-1:0]  dm1_s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s2 <= '0;
    end else if (adv) begin
      tag_s2.valid <= v_s1;
      tag_s2.oor   <= zero_s1 || (CMPW'(step_s1) > CMPW'(area_s1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dm1_s2 <= dm1_s1;
    end
  end

  logic [DW-1:0]  divisor;
  logic [SW-1:0]  line;
  logic [DW-1:0]  pos;
  ssci_pkg::tag_t tag_d;

  assign divisor = (scan_direction == ssci_pkg::SCAN_ALONG_COLS) ? DW'(rows) : DW'(cols);

  ssci_div #(
    .DW(DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .dividend  (dm1_s2),
    .divisor   (divisor),
    .tag_in    (tag_s2),
    .quotient  (line),
    .remainder (pos),
    .tag_out   (tag_d)
  );

  // Stage 3: row and column from line and position.
  logic          right;
  logic          bottom;
  logic          odd;
  logic [RW-1:0] row_c;
  logic [CW-1:0] col_c;

  assign right  = (start_corner == ssci_pkg::CORNER_TOP_RIGHT) ||
                  (start_corner == ssci_pkg::CORNER_BOTTOM_RIGHT);
  assign bottom = start_corner[1];
  assign odd    = line[0];

  always_comb begin
    if (scan_direction == ssci_pkg::SCAN_ALONG_ROWS) begin
      row_c = bottom ? (rows - RW'(1) - RW'(line)) : RW'(line);
      col_c = (right != odd) ? (cols - CW'(1) - CW'(pos)) : CW'(pos);
    end else begin
      col_c = right ? (cols - CW'(1) - CW'(line)) : CW'(line);
      row_c = (bottom != odd) ? (rows - RW'(1) - RW'(pos)) : RW'(pos);
    end
  end

  ssci_pkg::tag_t tag_s3;
  logic [RW-1:0]  row_s3;
  logic [CW-1:0]  col_s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s3 <= '0;
    end else if (adv) begin
      tag_s3 <= tag_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_s3 <= row_c;
      col_s3 <= col_c;
    end
  end

  // Stage 4: row offset.
  ssci_pkg::tag_t tag_s4;
  logic [PW-1:0]  base_s4;
  logic [CW-1:0]  col_s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s4 <= '0;
    end else if (adv) begin
      tag_s4 <= tag_s3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base_s4 <= PW'(row_s3) * PW'(cols);
      col_s4  <= col_s3;
    end
  end

  logic [SW-1:0] cell_c;

  assign cell_c = tag_s4.oor ? '0 : SW'(base_s4 + PW'(col_s4) + PW'(1));

  // Output register with skid stage.
  logic [SW-1:0] skid_cell;
  logic          skid_oor;
  logic          arriving;
  logic          out_free;

  assign arriving = adv && tag_s4.valid;
  assign out_free = !cell_valid || !cell_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      cell_valid <= skid_valid || arriving;
      skid_valid <= 1'b0;
    end else if (arriving) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        cell_number  <= skid_cell;
        out_of_range <= skid_oor;
      end else begin
        cell_number  <= cell_c;
        out_of_range <= tag_s4.oor;
      end
    end else if (arriving) begin
      skid_cell <= cell_c;
      skid_oor  <= tag_s4.oor;
    end
  end

endmodule

`default_nettype wire

[design/ssci_checker.sv]
`default_nettype none

module ssci_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        cfg_valid,
  input wire logic                        cfg_ready,
  input wire logic [1:0]                  cfg_index,
  input wire logic [ssci_pkg::CFG_W-1:0]  cfg_data,
  input wire logic                        step_valid,
  input wire logic                        step_stall,
  input wire logic [ssci_pkg::STEP_W-1:0] step_number,
  input wire logic                        cell_valid,
  input wire logic                        cell_stall,
  input wire logic [ssci_pkg::STEP_W-1:0] cell_number,
  input wire logic                        out_of_range
);

  // Reset empties the pipeline, so no result may follow it directly.
  a_reset_clears: assert property (@(posedge clk) rst |=> !cell_valid)
    else $error("result presented right after reset");

  // An out-of-range result always carries cell zero.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && out_of_range) |-> (cell_number == '0))
    else $error("out-of-range result with nonzero cell number");

  // Input back-pressure only starts after a result was held by the consumer.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(step_stall) |-> $past(cell_valid && cell_stall))
    else $error("input stalled without a blocked output transfer");

  // A held result stays in place until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (cell_valid && cell_stall) |=>
      (cell_valid && $stable(cell_number) && $stable(out_of_range)))
    else $error("stalled result changed");

endmodule

bind serpentine_scan_cell_index_unit ssci_checker u_ssci_checker (.*);

`default_nettype wire
